>>> design/julia_escape_time_pixel_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef JULIA_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define JULIA_ESCAPE_TIME_PIXEL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JETP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jetp check failed: same-cycle rule");

// The consequent must hold in the cycle after the antecedent.
`define JETP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jetp check failed: next-cycle rule");

`endif

>>> design/jetp_pkg.sv
`default_nettype none

package jetp_pkg;

   localparam int FRAC_BITS   = 28;
   localparam int COORD_WIDTH = 32;
   localparam int INDEX_WIDTH = 8;
   localparam int ID_WIDTH    = 8;
   localparam int ITER_WIDTH  = 8;

   localparam int IDX_PROD_W = INDEX_WIDTH + 1 + COORD_WIDTH;
   localparam int PROD_W     = 2 * COORD_WIDTH;
   localparam int WIDE_W     = PROD_W + 2;

   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_C_RE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_C_IM     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_RE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_IM  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_ITER = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_HALTED   = 3'd5;

   // Escape bound 4.0 at twice the fraction bits of one coordinate.
   localparam logic [PROD_W:0] ESC_LIMIT =
      {{PROD_W{1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

   localparam logic signed [WIDE_W-1:0] COORD_MAX =
      {{(WIDE_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] COORD_MIN =
      {{(WIDE_W - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};

   typedef struct packed {
      logic [ID_WIDTH-1:0]           chunk_id;
      logic signed [COORD_WIDTH-1:0] origin_re;
      logic signed [COORD_WIDTH-1:0] origin_im;
      logic [INDEX_WIDTH-1:0]        index_re;
      logic [INDEX_WIDTH-1:0]        index_im;
      logic                          last_pixel;
   } req_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0]    out_chunk_id;
      logic [INDEX_WIDTH-1:0] out_index_re;
      logic [INDEX_WIDTH-1:0] out_index_im;
      logic [ITER_WIDTH-1:0]  iterations;
      logic                   aborted;
      logic                   chunk_done;
   } rsp_type;

   typedef struct packed {
      logic                   en;
      logic [CSR_INDEX_W-1:0] index;
      logic [COORD_WIDTH-1:0] data;
   } csr_write_type;

   typedef struct packed {
      logic                  load;
      logic                  origin;
      logic                  mul;
      logic                  step;
      logic                  emit;
      logic                  emit_abort;
      logic [ITER_WIDTH-1:0] iterations;
   } cmd_type;

   typedef struct packed {
      logic                  escaped;
      logic                  halted;
      logic [ITER_WIDTH-1:0] max_iter;
   } status_type;

   function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
      input logic signed [WIDE_W-1:0] x
   );
      logic signed [COORD_WIDTH-1:0] r;
      if (x > COORD_MAX) begin
         r = COORD_MAX[COORD_WIDTH-1:0];
      end else if (x < COORD_MIN) begin
         r = COORD_MIN[COORD_WIDTH-1:0];
      end else begin
         r = x[COORD_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> design/jetp_ctrl.sv
`default_nettype none

module jetp_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire jetp_pkg::status_type status,
   output jetp_pkg::cmd_type         cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ORIGIN = 2'd1;
   localparam logic [1:0] ST_MUL    = 2'd2;
   localparam logic [1:0] ST_ADD    = 2'd3;

   logic [1:0]                       state_ff, state_in;
   logic                             first_ff, first_in;
   logic [jetp_pkg::ITER_WIDTH-1:0]  count_ff, count_in;

   always_comb begin
      state_in       = state_ff;
      first_in       = first_ff;
      count_in       = count_ff;
      cmd            = '0;
      cmd.iterations = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (status.halted) begin
                  cmd.emit_abort = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  first_in = 1'b1;
                  state_in = ST_ORIGIN;
               end
            end
         end
         ST_ORIGIN: begin
            cmd.origin = 1'b1;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (first_ff) begin
               // The first squaring is unconditional and sets the count to one.
               cmd.step = 1'b1;
               first_in = 1'b0;
               count_in = jetp_pkg::ITER_WIDTH'(1);
               state_in = ST_MUL;
            end else if (status.escaped || (count_ff > status.max_iter)) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.step = 1'b1;
               if (count_ff == status.max_iter) begin
                  cmd.emit = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  count_in = count_ff + jetp_pkg::ITER_WIDTH'(1);
                  state_in = ST_MUL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         first_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
         count_ff <= count_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

>>> design/jetp_dp.sv
`default_nettype none

module jetp_dp (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire jetp_pkg::req_type       req_data,
   input  wire jetp_pkg::csr_write_type csr_write,
   input  wire jetp_pkg::cmd_type       cmd,
   output jetp_pkg::status_type         status,
   output logic                         rsp_valid,
   output jetp_pkg::rsp_type            rsp_data
);

   localparam int CW         = jetp_pkg::COORD_WIDTH;
   localparam int FB         = jetp_pkg::FRAC_BITS;
   localparam int IDX_PROD_W = jetp_pkg::IDX_PROD_W;
   localparam int PROD_W     = jetp_pkg::PROD_W;
   localparam int WIDE_W     = jetp_pkg::WIDE_W;

   logic signed [CW-1:0]             c_re_ff, c_im_ff, step_re_ff, step_im_ff;
   logic [jetp_pkg::ITER_WIDTH-1:0]  max_iter_ff;
   logic                             halted_ff;

   jetp_pkg::req_type                item_ff, item_in;
   logic signed [IDX_PROD_W-1:0]     idx_prod_re_ff, idx_prod_re_in;
   logic signed [IDX_PROD_W-1:0]     idx_prod_im_ff, idx_prod_im_in;
   logic signed [CW-1:0]             re_ff, re_in, im_ff, im_in;
   logic signed [PROD_W-1:0]         rr_ff, rr_in, ii_ff, ii_in, ri_ff, ri_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   jetp_pkg::rsp_type                rsp_ff, rsp_in;

   logic signed [WIDE_W-1:0]         new_re_sum, new_im_sum;
   logic signed [WIDE_W-1:0]         org_re_sum, org_im_sum;
   logic [PROD_W:0]                  magnitude;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_re_ff     <= '0;
         c_im_ff     <= '0;
         step_re_ff  <= '0;
         step_im_ff  <= '0;
         max_iter_ff <= '0;
         halted_ff   <= 1'b0;
      end else if (csr_write.en) begin
         case (csr_write.index)
            jetp_pkg::REG_C_RE:     c_re_ff     <= csr_write.data;
            jetp_pkg::REG_C_IM:     c_im_ff     <= csr_write.data;
            jetp_pkg::REG_STEP_RE:  step_re_ff  <= csr_write.data;
            jetp_pkg::REG_STEP_IM:  step_im_ff  <= csr_write.data;
            jetp_pkg::REG_MAX_ITER: max_iter_ff <= csr_write.data[jetp_pkg::ITER_WIDTH-1:0];
            jetp_pkg::REG_HALTED:   halted_ff   <= csr_write.data[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      org_re_sum = WIDE_W'(idx_prod_re_ff) + WIDE_W'(item_ff.origin_re);
      org_im_sum = WIDE_W'(idx_prod_im_ff) + WIDE_W'(item_ff.origin_im);
      new_re_sum = (WIDE_W'(rr_ff) >>> FB) - (WIDE_W'(ii_ff) >>> FB) + WIDE_W'(c_re_ff);
      new_im_sum = (WIDE_W'(ri_ff) >>> (FB - 1)) + WIDE_W'(c_im_ff);
      magnitude  = {1'b0, rr_ff} + {1'b0, ii_ff};
   end

   always_comb begin
      item_in        = item_ff;
      idx_prod_re_in = idx_prod_re_ff;
      idx_prod_im_in = idx_prod_im_ff;
      re_in          = re_ff;
      im_in          = im_ff;
      rr_in          = rr_ff;
      ii_in          = ii_ff;
      ri_in          = ri_ff;
      rsp_valid_in   = cmd.emit || cmd.emit_abort;
      rsp_in         = rsp_ff;
      if (cmd.load) begin
         item_in        = req_data;
         idx_prod_re_in = IDX_PROD_W'($signed({1'b0, req_data.index_re}))
                          * IDX_PROD_W'(step_re_ff);
         idx_prod_im_in = IDX_PROD_W'($signed({1'b0, req_data.index_im}))
                          * IDX_PROD_W'(step_im_ff);
      end
      if (cmd.origin) begin
         re_in = jetp_pkg::sat_coord(org_re_sum);
         im_in = jetp_pkg::sat_coord(org_im_sum);
      end
      if (cmd.mul) begin
         rr_in = PROD_W'(re_ff) * PROD_W'(re_ff);
         ii_in = PROD_W'(im_ff) * PROD_W'(im_ff);
         ri_in = PROD_W'(re_ff) * PROD_W'(im_ff);
      end
      if (cmd.step) begin
         re_in = jetp_pkg::sat_coord(new_re_sum);
         im_in = jetp_pkg::sat_coord(new_im_sum);
      end
      if (cmd.emit_abort) begin
         rsp_in         = '0;
         rsp_in.aborted = 1'b1;
      end else if (cmd.emit) begin
         rsp_in.out_chunk_id = item_ff.chunk_id;
         rsp_in.out_index_re = item_ff.index_re;
         rsp_in.out_index_im = item_ff.index_im;
         rsp_in.iterations   = cmd.iterations;
         rsp_in.aborted      = 1'b0;
         rsp_in.chunk_done   = item_ff.last_pixel;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      idx_prod_re_ff <= idx_prod_re_in;
      idx_prod_im_ff <= idx_prod_im_in;
      re_ff          <= re_in;
      im_ff          <= im_in;
      rr_ff          <= rr_in;
      ii_ff          <= ii_in;
      ri_ff          <= ri_in;
      rsp_ff         <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.escaped  = (magnitude >= jetp_pkg::ESC_LIMIT);
   assign status.halted   = halted_ff;
   assign status.max_iter = max_iter_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule

`default_nettype wire

>>> design/julia_escape_time_pixel.sv
// Channel  Handshake                  Beat
// request  start / busy               req_data (jetp_pkg::req_type)
// result   rsp_valid, one-cycle pulse rsp_data (jetp_pkg::rsp_type)
// config   csr_valid / csr_ready      csr_index, csr_data
//
// Each squaring of z has two steps: the MUL state through the three 32x32
// multipliers, then the ADD state through the add, saturate and escape compare.
// A computed pixel passes the ORIGIN state, then squarings until escape or limit,
// reporting a count n of 1 to 255; a halted request gets an aborted beat.
// Reset is synchronous and clears the configuration registers and control.
// The receiver cannot stall; busy holds off new requests during a pixel.
`default_nettype none

module julia_escape_time_pixel (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire jetp_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   output jetp_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [jetp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [jetp_pkg::COORD_WIDTH-1:0]    csr_data
);

   jetp_pkg::cmd_type       cmd;
   jetp_pkg::status_type    status;
   jetp_pkg::csr_write_type csr_write;

   assign csr_ready       = 1'b1;
   assign csr_write.en    = csr_valid && csr_ready;
   assign csr_write.index = csr_index;
   assign csr_write.data  = csr_data;

   jetp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   jetp_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_write),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> design/jetp_checker.sv
`default_nettype none
`include "julia_escape_time_pixel_defines.svh"

module jetp_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic                                busy,
   input  wire logic                                rsp_valid,
   input  wire jetp_pkg::rsp_type                   rsp_data
);

   // An aborted beat carries nothing but the abort flag.
   `JETP_ASSERT_SAME(a_abort_clean, clock, reset, rsp_valid && rsp_data.aborted, (rsp_data.out_chunk_id == '0) && (rsp_data.out_index_re == '0) && (rsp_data.out_index_im == '0) && (rsp_data.iterations == '0) && !rsp_data.chunk_done)

   // A computed beat counts at least one iteration and leaves the block idle.
   `JETP_ASSERT_SAME(a_computed_beat, clock, reset, rsp_valid && !rsp_data.aborted, (rsp_data.iterations != '0) && !busy)

   // Finishing a pixel always delivers its computed result.
   `JETP_ASSERT_SAME(a_finish_delivers, clock, reset, !busy && $past(busy) && !$past(reset), rsp_valid && !rsp_data.aborted)

   // An accepted request is either answered at once or keeps the block busy.
   `JETP_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, rsp_valid || busy)

endmodule

bind julia_escape_time_pixel jetp_checker u_checker (.*);

`default_nettype wire

>>> verif/julia_escape_time_pixel_test.sv
`timescale 1ns / 100ps

module julia_escape_time_pixel_test;

   localparam int FRAC_BITS   = jetp_pkg::FRAC_BITS;
   localparam int COORD_WIDTH = jetp_pkg::COORD_WIDTH;
   localparam int INDEX_WIDTH = jetp_pkg::INDEX_WIDTH;
   localparam int ID_WIDTH    = jetp_pkg::ID_WIDTH;
   localparam int ITER_WIDTH  = jetp_pkg::ITER_WIDTH;
   localparam int CSR_INDEX_W = jetp_pkg::CSR_INDEX_W;

   localparam int CYCLE_LIMIT = 5_000_000;
   localparam int TAIL_CYCLES = 600;
   localparam int SEGMENTS    = 8;
   localparam int SEG_PIXELS  = 250;
   localparam int ONE_Q       = 1 << FRAC_BITS;
   localparam int TWO_Q       = 2 * ONE_Q;

   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_A = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_B = 3'd7;

   localparam logic signed [127:0] COORD_HI = (128'sd1 <<< (COORD_WIDTH - 1)) - 128'sd1;
   localparam logic signed [127:0] COORD_LO = -(128'sd1 <<< (COORD_WIDTH - 1));
   localparam logic signed [127:0] ESCAPE_RADIUS_SQ = 128'sd1 <<< (2 * FRAC_BITS + 2);

   typedef enum logic [1:0] {
      JOB_PIXEL,
      JOB_CSR,
      JOB_DRAIN,
      JOB_PHASE
   } job_kind_type;

   typedef struct {
      job_kind_type           kind;
      jetp_pkg::req_type      pixel;
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [COORD_WIDTH-1:0] reg_value;
      int                     idle_pct;
   } job_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   jetp_pkg::req_type req_data = '0;
   logic rsp_valid;
   jetp_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [COORD_WIDTH-1:0] csr_data = '0;

   logic signed [COORD_WIDTH-1:0] julia_c_re = '0;
   logic signed [COORD_WIDTH-1:0] julia_c_im = '0;
   logic signed [COORD_WIDTH-1:0] pitch_re = '0;
   logic signed [COORD_WIDTH-1:0] pitch_im = '0;
   logic [ITER_WIDTH-1:0] iter_limit = '0;
   logic halt_flag = 1'b0;

   job_type jobs[$];
   jetp_pkg::rsp_type expected_pixels[$];
   int idle_pct = 0;
   int failures = 0;
   int cycle_count = 0;

   julia_escape_time_pixel dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(logic signed [127:0] x);
      if (x > COORD_HI) begin
         return COORD_HI[COORD_WIDTH-1:0];
      end else if (x < COORD_LO) begin
         return COORD_LO[COORD_WIDTH-1:0];
      end
      return x[COORD_WIDTH-1:0];
   endfunction

   function automatic void square_plus_c(inout logic signed [COORD_WIDTH-1:0] re,
                                         inout logic signed [COORD_WIDTH-1:0] im);
      logic signed [127:0] wr, wi, wc_re, wc_im, rr, ii, ri;
      wr = re;
      wi = im;
      wc_re = julia_c_re;
      wc_im = julia_c_im;
      rr = (wr * wr) >>> FRAC_BITS;
      ii = (wi * wi) >>> FRAC_BITS;
      ri = (wr * wi) >>> (FRAC_BITS - 1);
      re = clamp_coord(rr - ii + wc_re);
      im = clamp_coord(ri + wc_im);
   endfunction

   function automatic bit within_radius(logic signed [COORD_WIDTH-1:0] re,
                                        logic signed [COORD_WIDTH-1:0] im);
      logic signed [127:0] wr, wi;
      wr = re;
      wi = im;
      return (wr * wr + wi * wi) < ESCAPE_RADIUS_SQ;
   endfunction

   function automatic jetp_pkg::rsp_type escape_time(jetp_pkg::req_type px);
      jetp_pkg::rsp_type r;
      logic signed [127:0] ix, iy, wo_re, wo_im, ws_re, ws_im;
      logic signed [COORD_WIDTH-1:0] re, im;
      int count;
      r = '0;
      if (halt_flag) begin
         r.aborted = 1'b1;
         return r;
      end
      ix = '0;
      iy = '0;
      ix[INDEX_WIDTH-1:0] = px.index_re;
      iy[INDEX_WIDTH-1:0] = px.index_im;
      wo_re = $signed(px.origin_re);
      wo_im = $signed(px.origin_im);
      ws_re = pitch_re;
      ws_im = pitch_im;
      re = clamp_coord(ix * ws_re + wo_re);
      im = clamp_coord(iy * ws_im + wo_im);
      square_plus_c(re, im);
      count = 1;
      while (within_radius(re, im) && count <= iter_limit) begin
         square_plus_c(re, im);
         if (count != iter_limit) begin
            count++;
         end else begin
            break;
         end
      end
      r.out_chunk_id = px.chunk_id;
      r.out_index_re = px.index_re;
      r.out_index_im = px.index_im;
      r.iterations = count[ITER_WIDTH-1:0];
      r.chunk_done = px.last_pixel;
      return r;
   endfunction

   function automatic void store_register(logic [CSR_INDEX_W-1:0] idx,
                                          logic [COORD_WIDTH-1:0] value);
      case (idx)
         jetp_pkg::REG_C_RE: julia_c_re = value;
         jetp_pkg::REG_C_IM: julia_c_im = value;
         jetp_pkg::REG_STEP_RE: pitch_re = value;
         jetp_pkg::REG_STEP_IM: pitch_im = value;
         jetp_pkg::REG_MAX_ITER: iter_limit = value[ITER_WIDTH-1:0];
         jetp_pkg::REG_HALTED: halt_flag = value[0];
         default: ;
      endcase
   endfunction

   function automatic logic [COORD_WIDTH-1:0] rand_coord(int unsigned span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   function automatic void add_pixel(logic [ID_WIDTH-1:0] chunk,
                                     logic [COORD_WIDTH-1:0] ore,
                                     logic [COORD_WIDTH-1:0] oim,
                                     logic [INDEX_WIDTH-1:0] ir,
                                     logic [INDEX_WIDTH-1:0] ij,
                                     logic last);
      job_type j;
      j = '{kind: JOB_PIXEL, pixel: '0, reg_index: '0, reg_value: '0, idle_pct: 0};
      j.pixel.chunk_id = chunk;
      j.pixel.origin_re = ore;
      j.pixel.origin_im = oim;
      j.pixel.index_re = ir;
      j.pixel.index_im = ij;
      j.pixel.last_pixel = last;
      jobs.push_back(j);
   endfunction

   function automatic void add_register(logic [CSR_INDEX_W-1:0] idx,
                                        logic [COORD_WIDTH-1:0] value);
      jobs.push_back('{kind: JOB_CSR, pixel: '0, reg_index: idx, reg_value: value,
                       idle_pct: 0});
   endfunction

   function automatic void add_drain();
      jobs.push_back('{kind: JOB_DRAIN, pixel: '0, reg_index: '0, reg_value: '0,
                       idle_pct: 0});
   endfunction

   function automatic void add_phase(int pct);
      jobs.push_back('{kind: JOB_PHASE, pixel: '0, reg_index: '0, reg_value: '0,
                       idle_pct: pct});
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin : driver
      logic start_next, csr_next, idle_now;
      if (reset) begin
         start <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         start_next = start && busy;
         csr_next = csr_valid && !csr_ready;
         if (start && !busy) begin
            expected_pixels.push_back(escape_time(req_data));
         end
         if (csr_valid && csr_ready) begin
            store_register(csr_index, csr_data);
         end
         // rsp_valid low means the monitor does not pop at this edge.
         idle_now = !start_next && !csr_next && !busy && !rsp_valid &&
                    expected_pixels.size() == 0;
         if (!start_next && !csr_next && jobs.size() > 0) begin
            case (jobs[0].kind)
               JOB_PIXEL: begin
                  if ($urandom_range(99) >= idle_pct) begin
                     req_data <= jobs[0].pixel;
                     start_next = 1'b1;
                     jobs.pop_front();
                  end
               end
               JOB_CSR: begin
                  if (idle_now) begin
                     csr_index <= jobs[0].reg_index;
                     csr_data <= jobs[0].reg_value;
                     csr_next = 1'b1;
                     jobs.pop_front();
                  end
               end
               JOB_DRAIN: begin
                  if (idle_now) begin
                     jobs.pop_front();
                  end
               end
               JOB_PHASE: begin
                  idle_pct = jobs[0].idle_pct;
                  jobs.pop_front();
               end
               default: begin
                  jobs.pop_front();
               end
            endcase
         end
         start <= start_next;
         csr_valid <= csr_next;
      end
   end

   always @(posedge clock) begin : monitor
      jetp_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_pixels.size() == 0) begin
            $error("result beat with no pixel outstanding");
            failures++;
         end else begin
            want = expected_pixels.pop_front();
            check_field("out_chunk_id", want.out_chunk_id, rsp_data.out_chunk_id);
            check_field("out_index_re", want.out_index_re, rsp_data.out_index_re);
            check_field("out_index_im", want.out_index_im, rsp_data.out_index_im);
            check_field("iterations", want.iterations, rsp_data.iterations);
            check_field("aborted", want.aborted, rsp_data.aborted);
            check_field("chunk_done", want.chunk_done, rsp_data.chunk_done);
         end
      end
   end

   initial begin
      int seg, sent, size, limit;
      logic [ID_WIDTH-1:0] chunk;
      logic [COORD_WIDTH-1:0] ore, oim;
      logic [INDEX_WIDTH-1:0] base_re, base_im;

      add_phase(0);
      add_pixel(8'h00, 32'h0, 32'h0, 8'h00, 8'h00, 1'b0);
      add_pixel(8'hFF, 32'h7FFF_FFFF, 32'h8000_0000, 8'hFF, 8'hFF, 1'b1);
      add_register(jetp_pkg::REG_C_RE, -(ONE_Q / 5 * 4));
      add_register(jetp_pkg::REG_C_IM, ONE_Q / 25 * 4);
      add_register(jetp_pkg::REG_STEP_RE, ONE_Q >> 6);
      add_register(jetp_pkg::REG_STEP_IM, ONE_Q >> 6);
      add_register(jetp_pkg::REG_MAX_ITER, 32'hABCD_12FF);
      add_register(jetp_pkg::REG_HALTED, 32'hFFFF_FFFE);
      add_register(REG_UNUSED_A, 32'hFFFF_FFFF);
      add_register(REG_UNUSED_B, 32'h5555_AAAA);
      add_pixel(8'h01, 32'h0, 32'h0, 8'h00, 8'h00, 1'b0);
      add_pixel(8'h02, -TWO_Q, -TWO_Q, 8'hFF, 8'hFF, 1'b1);
      add_pixel(8'h03, 32'h8000_0000, 32'h7FFF_FFFF, 8'h00, 8'h00, 1'b0);
      add_pixel(8'h04, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'hFF, 8'hFF, 1'b1);
      add_register(jetp_pkg::REG_C_RE, 32'h7FFF_FFFF);
      add_register(jetp_pkg::REG_C_IM, 32'h8000_0000);
      add_register(jetp_pkg::REG_STEP_RE, 32'h7FFF_FFFF);
      add_register(jetp_pkg::REG_STEP_IM, 32'h8000_0000);
      add_register(jetp_pkg::REG_MAX_ITER, 32'h0);
      add_pixel(8'hAA, 32'h0, 32'h0, 8'hFF, 8'hFF, 1'b0);
      add_pixel(8'h55, 32'h7FFF_FFFF, 32'h8000_0000, 8'hFF, 8'hFF, 1'b1);
      add_pixel(8'h10, 32'h8000_0000, 32'h7FFF_FFFF, 8'h00, 8'h00, 1'b0);
      add_register(jetp_pkg::REG_C_RE, 32'h0);
      add_register(jetp_pkg::REG_C_IM, 32'h0);
      add_register(jetp_pkg::REG_STEP_RE, 32'h0);
      add_register(jetp_pkg::REG_STEP_IM, 32'h0);
      add_register(jetp_pkg::REG_MAX_ITER, 32'h1);
      add_pixel(8'h20, 32'h0, 32'h0, 8'h01, 8'h02, 1'b0);
      add_pixel(8'h21, ONE_Q, 32'h0, 8'h00, 8'h00, 1'b1);
      add_register(jetp_pkg::REG_MAX_ITER, 32'hFF);
      add_pixel(8'h22, ONE_Q, 32'h0, 8'h00, 8'h00, 1'b0);
      add_pixel(8'h23, TWO_Q, 32'h0, 8'h00, 8'h00, 1'b1);
      add_register(jetp_pkg::REG_HALTED, 32'h1);
      add_pixel(8'hC3, 32'h1234_5678, 32'h8765_4321, 8'h5A, 8'hA5, 1'b1);
      add_pixel(8'h3C, 32'h0, 32'h0, 8'hFF, 8'h00, 1'b0);
      add_register(jetp_pkg::REG_HALTED, 32'h0);
      add_drain();

      for (seg = 0; seg < SEGMENTS; seg++) begin
         case (seg % 3)
            0: add_phase(0);
            1: add_phase(72);
            default: add_phase(36);
         endcase
         case (seg)
            3: limit = 255;
            5: limit = 0;
            6: limit = 1;
            default: limit = $urandom_range(2, 48);
         endcase
         add_register(jetp_pkg::REG_C_RE, rand_coord(ONE_Q));
         add_register(jetp_pkg::REG_C_IM, rand_coord(ONE_Q));
         add_register(jetp_pkg::REG_STEP_RE, rand_coord(ONE_Q >> 5));
         add_register(jetp_pkg::REG_STEP_IM, rand_coord(ONE_Q >> 5));
         add_register(jetp_pkg::REG_MAX_ITER, ($urandom & 32'hFFFF_FF00) | limit);
         add_register(jetp_pkg::REG_HALTED, ($urandom & 32'hFFFF_FFFE) | 32'(seg == 4));
         add_register($urandom_range(1) ? REG_UNUSED_A : REG_UNUSED_B, $urandom);
         sent = 0;
         while (sent < SEG_PIXELS) begin
            if ($urandom_range(99) < 10) begin
               add_pixel(ID_WIDTH'($urandom), $urandom, $urandom,
                         INDEX_WIDTH'($urandom), INDEX_WIDTH'($urandom), 1'($urandom));
               sent++;
            end else begin
               size = $urandom_range(1, 12);
               chunk = ID_WIDTH'($urandom);
               if ($urandom_range(99) < 80) begin
                  ore = rand_coord(TWO_Q);
                  oim = rand_coord(TWO_Q);
               end else begin
                  ore = $urandom;
                  oim = $urandom;
               end
               base_re = INDEX_WIDTH'($urandom);
               base_im = INDEX_WIDTH'($urandom);
               for (int k = 0; k < size; k++) begin
                  add_pixel(chunk, ore, oim, base_re + k[INDEX_WIDTH-1:0],
                            ($urandom_range(1) ? base_im : INDEX_WIDTH'($urandom)),
                            k == size - 1);
               end
               sent += size;
            end
            if ($urandom_range(99) < 4) begin
               add_drain();
            end
         end
      end

      @(negedge reset);
      while (jobs.size() != 0 || start || csr_valid || expected_pixels.size() != 0) begin
         @(negedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
